@@ hdl/scbi_pkg.sv @@
// ----------------------------------------------------------------------------
// scbi_pkg
// Shared types, constants and the structural character decode for the
// structural character bitmap index.
// ----------------------------------------------------------------------------
package scbi_pkg;

    localparam int MAX_BYTES  = 4096;
    localparam int WORD_BITS  = 64;
    localparam int WORD_COUNT = MAX_BYTES / WORD_BITS;
    localparam int POS_W      = 13;
    localparam int FPOS_W     = 12;
    localparam int WIDX_W     = 6;

    localparam logic [POS_W-1:0] MAX_LEN    = POS_W'(MAX_BYTES);
    localparam logic [POS_W-1:0] POS_SAT    = {POS_W{1'b1}};
    localparam logic [POS_W-1:0] LEN_RESET  = POS_W'(MAX_BYTES);

    // item kinds
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // structural characters
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;

    typedef struct packed {
        logic             op;
        logic             is_struct;
        logic             last;
        logic [POS_W-1:0] qpos;
    } cmd_t;

    typedef struct packed {
        logic              is_structural;
        logic [POS_W-1:0]  structural_count;
        logic              overflow;
        logic              found;
        logic [FPOS_W-1:0] found_position;
        logic [POS_W-1:0]  next_position;
    } res_t;

    function automatic logic is_struct_char(input logic [7:0] b);
        return (b == CH_LBRACE) || (b == CH_RBRACE) || (b == CH_LBRACK) ||
               (b == CH_RBRACK) || (b == CH_COLON)  || (b == CH_COMMA)  ||
               (b == CH_DQUOTE);
    endfunction

endpackage

@@ hdl/scbi_front.sv @@
// ----------------------------------------------------------------------------
// scbi_front
// Input side: accepts item beats, decodes the text byte and holds the
// classified commands in a four-entry queue for the back end.
// ----------------------------------------------------------------------------
module scbi_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         op,
    input  logic [7:0]                   data_byte,
    input  logic                         last_byte,
    input  logic [scbi_pkg::POS_W-1:0]   query_position,
    output logic                         cmd_valid,
    output scbi_pkg::cmd_t               cmd,
    input  logic                         cmd_take
);
    import scbi_pkg::*;

    localparam int DEPTH = 4;

    cmd_t       q_mem [0:DEPTH-1];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       do_push;
    logic       do_pop;
    cmd_t       cmd_in;

    assign full      = (cnt_reg == 3'(DEPTH));
    assign cmd_valid = (cnt_reg != 3'd0);
    assign cmd       = q_mem[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        cmd_in.op        = op;
        cmd_in.is_struct = is_struct_char(data_byte);
        cmd_in.last      = last_byte;
        cmd_in.qpos      = query_position;
    end

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 2'd1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 2'd1 : rd_ptr_reg;
        cnt_next    = cnt_reg + {2'b00, do_push} - {2'b00, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            cnt_reg    <= 3'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // hold the payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

@@ hdl/scbi_back.sv @@
// ----------------------------------------------------------------------------
// scbi_back
// Execution side: marks structural positions in the bitmap memory, walks
// bitmap words for queries and queues results for the consumer.
// ----------------------------------------------------------------------------
module scbi_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [scbi_pkg::POS_W-1:0]   eff_len,
    input  logic                         cmd_valid,
    input  scbi_pkg::cmd_t               cmd,
    output logic                         cmd_take,
    output logic                         empty,
    input  logic                         pop,
    output scbi_pkg::res_t               res
);
    import scbi_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DATA  = 2'd2;
    localparam logic [1:0] ST_FIND  = 2'd3;

    // bitmap memory with per-word valid bits
    logic [WORD_BITS-1:0]  bmp_mem [0:WORD_COUNT-1];
    logic [WORD_BITS-1:0]  rd_data_reg;
    logic                  rd_valid_reg;
    logic [WORD_COUNT-1:0] word_valid_reg, word_valid_next;
    logic                  mem_we;
    logic [WIDX_W-1:0]     mem_waddr;
    logic [WIDX_W-1:0]     mem_raddr;

    logic [1:0]            state_reg, state_next;
    logic [POS_W-1:0]      wp_reg, wp_next;
    logic [POS_W-1:0]      cnt_reg, cnt_next;
    logic                  scan_open_reg, scan_open_next;
    logic [WORD_BITS-1:0]  acc_reg, acc_next;
    logic [WIDX_W:0]       widx_reg, widx_next;
    logic [WIDX_W-1:0]     bit_reg, bit_next;
    logic [POS_W-1:0]      qpos_reg, qpos_next;
    logic [7:0]            byte_reg, byte_next;
    logic [2:0]            byte_idx_reg, byte_idx_next;

    // result queue
    res_t                  res_mem [0:1];
    logic                  res_wr_ptr_reg, res_rd_ptr_reg;
    logic [1:0]            res_cnt_reg;
    logic                  res_room;
    logic                  res_push;
    logic                  res_pop;
    res_t                  res_in;

    // push path
    logic                  start;
    logic [POS_W-1:0]      pos;
    logic [POS_W-1:0]      cnt_base;
    logic                  in_buf;
    logic                  mark;
    logic [WORD_BITS-1:0]  acc_new;
    logic [POS_W-1:0]      cnt_new;

    // query path
    logic [WIDX_W:0]       words_used;
    logic [WORD_BITS-1:0]  masked;
    logic                  any_byte;
    logic [2:0]            sel_idx;
    logic [2:0]            bit_in_byte;
    logic [FPOS_W-1:0]     hit;
    logic                  hit_ok;

    assign res_room  = (res_cnt_reg != 2'd2);
    assign empty     = (res_cnt_reg == 2'd0);
    assign res_pop   = pop && !empty;
    assign res       = res_mem[res_rd_ptr_reg];
    assign mem_raddr = widx_reg[WIDX_W-1:0];

    assign words_used = 7'((eff_len + 13'd63) >> 6);

    // push item, evaluated in idle
    always_comb
    begin
        start    = !scan_open_reg;
        pos      = start ? '0 : wp_reg;
        cnt_base = start ? '0 : cnt_reg;
        in_buf   = (pos < eff_len);
        mark     = in_buf && cmd.is_struct;
        acc_new  = ((start || (pos[5:0] == 6'd0)) ? '0 : acc_reg) |
                   (mark ? (64'd1 << pos[5:0]) : '0);
        cnt_new  = mark ? cnt_base + 13'd1 : cnt_base;
    end

    // query word scan: pick the lowest nonzero byte of the masked word
    always_comb
    begin
        masked   = rd_valid_reg ? (rd_data_reg & ({WORD_BITS{1'b1}} << bit_reg)) : '0;
        any_byte = |masked;
        sel_idx  = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (|masked[8*i +: 8])
            begin
                sel_idx = 3'(i);
            end
        end
    end

    // finish: lowest bit within the selected byte
    always_comb
    begin
        bit_in_byte = 3'd0;
        for (int j = 7; j >= 0; j--)
        begin
            if (byte_reg[j])
            begin
                bit_in_byte = 3'(j);
            end
        end
        hit    = {widx_reg[WIDX_W-1:0], byte_idx_reg, bit_in_byte};
        hit_ok = ({1'b0, hit} < eff_len);
    end

    always_comb
    begin
        state_next      = state_reg;
        wp_next         = wp_reg;
        cnt_next        = cnt_reg;
        scan_open_next  = scan_open_reg;
        acc_next        = acc_reg;
        widx_next       = widx_reg;
        bit_next        = bit_reg;
        qpos_next       = qpos_reg;
        byte_next       = byte_reg;
        byte_idx_next   = byte_idx_reg;
        word_valid_next = word_valid_reg;
        mem_we          = 1'b0;
        mem_waddr       = pos[11:6];
        cmd_take        = 1'b0;
        res_push        = 1'b0;
        res_in          = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && res_room)
                begin
                    cmd_take = 1'b1;
                    if (cmd.op == OP_PUSH)
                    begin
                        wp_next        = (pos == POS_SAT) ? pos : pos + 13'd1;
                        cnt_next       = cnt_new;
                        scan_open_next = !cmd.last;
                        acc_next       = acc_new;
                        mem_we         = mark;
                        if (start)
                        begin
                            word_valid_next = '0;
                        end
                        if (mark)
                        begin
                            word_valid_next[pos[11:6]] = 1'b1;
                        end
                        res_push                = 1'b1;
                        res_in.is_structural    = mark;
                        res_in.structural_count = cnt_new;
                        res_in.overflow         = !in_buf;
                    end
                    else
                    begin
                        qpos_next  = cmd.qpos;
                        widx_next  = cmd.qpos[12:6];
                        bit_next   = cmd.qpos[5:0];
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (widx_reg >= words_used)
                begin
                    res_push             = 1'b1;
                    res_in.next_position = qpos_reg;
                    state_next           = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (any_byte)
                begin
                    byte_next     = masked[8*sel_idx +: 8];
                    byte_idx_next = sel_idx;
                    state_next    = ST_FIND;
                end
                else
                begin
                    widx_next  = widx_reg + 7'd1;
                    bit_next   = '0;
                    state_next = ST_CHECK;
                end
            end
            ST_FIND:
            begin
                res_push = 1'b1;
                if (hit_ok)
                begin
                    res_in.found          = 1'b1;
                    res_in.found_position = hit;
                    res_in.next_position  = {1'b0, hit} + 13'd1;
                end
                else
                begin
                    res_in.next_position = qpos_reg;
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            wp_reg         <= '0;
            cnt_reg        <= '0;
            scan_open_reg  <= 1'b0;
            word_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            res_wr_ptr_reg <= 1'b0;
            res_rd_ptr_reg <= 1'b0;
            res_cnt_reg    <= 2'd0;
        end
        else
        begin
            state_reg      <= state_next;
            wp_reg         <= wp_next;
            cnt_reg        <= cnt_next;
            scan_open_reg  <= scan_open_next;
            word_valid_reg <= word_valid_next;
            rd_valid_reg   <= word_valid_reg[mem_raddr];
            if (res_push)
            begin
                res_wr_ptr_reg <= !res_wr_ptr_reg;
            end
            if (res_pop)
            begin
                res_rd_ptr_reg <= !res_rd_ptr_reg;
            end
            res_cnt_reg <= res_cnt_reg + {1'b0, res_push} - {1'b0, res_pop};
        end
    end

    // working registers and payload; no reset needed
    always_ff @(posedge clk)
    begin
        acc_reg      <= acc_next;
        widx_reg     <= widx_next;
        bit_reg      <= bit_next;
        qpos_reg     <= qpos_next;
        byte_reg     <= byte_next;
        byte_idx_reg <= byte_idx_next;
        if (res_push)
        begin
            res_mem[res_wr_ptr_reg] <= res_in;
        end
    end

    // bitmap memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bmp_mem[mem_waddr] <= acc_new;
        end
        rd_data_reg <= bmp_mem[mem_raddr];
    end

endmodule

@@ hdl/structural_char_bitmap_index_core.sv @@
// ----------------------------------------------------------------------------
// structural_char_bitmap_index_core
// Structural character bitmap index: marks the positions of { } [ ] : ,
// and double quote in a text stream and answers next-position queries.
// ----------------------------------------------------------------------------
// Both sides behave as queues. A push item (op 0) carries one text byte; the
// first byte after reset or after a byte flagged last_byte opens a new scan
// and clears the bitmap in the same cycle (per-word valid bits drop at once,
// so there is no clearing pass). Bytes at or beyond the effective length
// (buffer_length capped at 4096) are dropped and reported with overflow.
// A query item (op 1) searches forward from query_position for the next
// marked position below the effective length. The back end executes a push
// in its idle state, so bytes stream at one per clock while the result queue
// has room and no query is in progress. Each 64-bit bitmap word a query
// visits passes a check state, which issues a registered read of the bitmap
// memory, and an evaluation state; a hit adds a find state for the bit.
// A four-beat command queue in front and a two-beat result queue at the
// output let the producer and the consumer stall independently.
// buffer_length lives at byte address 0 of the APB port; the user must write
// it only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module structural_char_bitmap_index_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // item queue
    input  logic                          push,
    output logic                          full,
    input  logic                          op,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    input  logic [scbi_pkg::POS_W-1:0]    query_position,
    // result queue
    output logic                          empty,
    input  logic                          pop,
    output logic                          is_structural,
    output logic [scbi_pkg::POS_W-1:0]    structural_count,
    output logic                          overflow,
    output logic                          found,
    output logic [scbi_pkg::FPOS_W-1:0]   found_position,
    output logic [scbi_pkg::POS_W-1:0]    next_position
);
    import scbi_pkg::*;

    logic [POS_W-1:0] buf_len_reg, buf_len_next;
    logic [POS_W-1:0] eff_len;
    logic             cfg_wr;
    logic             cmd_valid;
    logic             cmd_take;
    cmd_t             cmd;
    res_t             res;

    // register 0 sits at byte address 0; paddr[2] selects beyond the map
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {{(32-POS_W){1'b0}}, buf_len_reg};

    always_comb
    begin
        buf_len_next = cfg_wr ? pwdata[POS_W-1:0] : buf_len_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_len_reg <= LEN_RESET;
        end
        else
        begin
            buf_len_reg <= buf_len_next;
        end
    end

    // cap the programmed length at the bitmap size
    assign eff_len = (buf_len_reg > MAX_LEN) ? MAX_LEN : buf_len_reg;

    // classify and queue incoming beats
    scbi_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .op             (op),
        .data_byte      (data_byte),
        .last_byte      (last_byte),
        .query_position (query_position),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_take       (cmd_take)
    );

    // mark, walk and deliver results
    scbi_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .eff_len   (eff_len),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .res       (res)
    );

    // break the head-of-queue result into its fields
    assign is_structural    = res.is_structural;
    assign structural_count = res.structural_count;
    assign overflow         = res.overflow;
    assign found            = res.found;
    assign found_position   = res.found_position;
    assign next_position    = res.next_position;

endmodule
